>>> src/header_tail_frame_scaler_assert.svh
// ----------------------------------------------------------------------------
// header_tail_frame_scaler assertion macros
// Shared concurrent assertion forms for the frame scaler checkers.
// ----------------------------------------------------------------------------
`ifndef HEADER_TAIL_FRAME_SCALER_ASSERT_SVH
`define HEADER_TAIL_FRAME_SCALER_ASSERT_SVH

// Checked on every rising clock edge, suspended while reset is asserted.
`define HTFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define HTFS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/htfs_pkg.sv
// ----------------------------------------------------------------------------
// htfs_pkg
// Types, constants and helpers shared by the frame scaler modules.
// ----------------------------------------------------------------------------
package htfs_pkg;

    // Field widths.
    localparam int BYTE_W = 8;
    localparam int POS_W  = 6;
    localparam int IDX_W  = 6;
    localparam int VAL_W  = 14;

    // Default frame lengths in bytes, header and tail included.
    localparam int SHORT_FRAME_BYTES_DEF = 6;
    localparam int LONG_FRAME_BYTES_DEF  = 40;

    // Frame length limits.
    localparam int MIN_FRAME_BYTES = 3;
    localparam int MAX_FRAME_BYTES = 64;

    // Framing bytes and the scale factor 0.43 held in hundredths.
    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hE6;
    localparam logic [BYTE_W-1:0] TAIL_BYTE   = 8'hFF;
    localparam logic [VAL_W-1:0]  SCALE_HUNDREDTHS = 14'd43;

    // Controller states.
    typedef enum logic [1:0] {
        ST_RX,
        ST_LOAD,
        ST_HOLD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic rx_take;
        logic rd_start;
        logic rd_next;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tail_good;
        logic rd_last;
    } status_t;

    // Limits a frame length to the supported range.
    function automatic int clamp_len(input int n);
        int r;
        r = n;
        if (n < MIN_FRAME_BYTES) r = MIN_FRAME_BYTES;
        if (n > MAX_FRAME_BYTES) r = MAX_FRAME_BYTES;
        return r;
    endfunction

    // Address width of a buffer with the given depth.
    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

>>> src/htfs_ram.sv
// ----------------------------------------------------------------------------
// htfs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module htfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/htfs_datapath.sv
// ----------------------------------------------------------------------------
// htfs_datapath
// Mode register, per-mode position counters, payload buffers, read index and
// the scaled output register.
// ----------------------------------------------------------------------------
module htfs_datapath #(
    parameter int SHORT_FRAME_BYTES = htfs_pkg::SHORT_FRAME_BYTES_DEF,
    parameter int LONG_FRAME_BYTES  = htfs_pkg::LONG_FRAME_BYTES_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_mode,
    input  logic [htfs_pkg::BYTE_W-1:0] rx_byte,
    input  htfs_pkg::cmd_t           cmd,
    output htfs_pkg::status_t        status,
    output logic [htfs_pkg::IDX_W-1:0] item_index,
    output logic [htfs_pkg::VAL_W-1:0] value_hundredths,
    output logic                     last
);
    import htfs_pkg::*;

    localparam int SHORT_LEN = clamp_len(SHORT_FRAME_BYTES);
    localparam int LONG_LEN  = clamp_len(LONG_FRAME_BYTES);
    localparam int SHORT_PAY = SHORT_LEN - 2;
    localparam int LONG_PAY  = LONG_LEN - 2;
    localparam int SAW = addr_w(SHORT_PAY);
    localparam int LAW = addr_w(LONG_PAY);
    localparam logic [POS_W-1:0] SHORT_TAIL = POS_W'(SHORT_LEN - 1);
    localparam logic [POS_W-1:0] LONG_TAIL  = POS_W'(LONG_LEN - 1);
    localparam logic [POS_W-1:0] SHORT_LAST = POS_W'(SHORT_PAY - 1);
    localparam logic [POS_W-1:0] LONG_LAST  = POS_W'(LONG_PAY - 1);

    logic             mode_reg;
    logic [POS_W-1:0] short_pos_reg, short_pos_next;
    logic [POS_W-1:0] long_pos_reg, long_pos_next;
    logic [POS_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] item_index_reg;
    logic [VAL_W-1:0] value_reg;
    logic             last_reg;

    logic [POS_W-1:0] cur_pos, cur_tail, pos_after, wr_addr;
    logic             wr_en;
    logic [BYTE_W-1:0] short_rdata, long_rdata, rd_byte;

    // Mode register, written from the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_mode;
        end
    end

    // Position of the selected mode and its successor.
    assign cur_pos  = mode_reg ? long_pos_reg : short_pos_reg;
    assign cur_tail = mode_reg ? LONG_TAIL : SHORT_TAIL;

    always_comb
    begin
        priority if (cur_pos == '0)
        begin
            pos_after = (rx_byte == HEADER_BYTE) ? POS_W'(1) : '0;
        end
        else if (cur_pos == cur_tail)
        begin
            pos_after = '0;
        end
        else
        begin
            pos_after = cur_pos + POS_W'(1);
        end
    end

    // Only the selected mode advances; the other keeps its place.
    always_comb
    begin
        short_pos_next = short_pos_reg;
        long_pos_next  = long_pos_reg;
        if (cmd.rx_take)
        begin
            if (mode_reg)
            begin
                long_pos_next = pos_after;
            end
            else
            begin
                short_pos_next = pos_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_pos_reg <= '0;
            long_pos_reg  <= '0;
        end
        else
        begin
            short_pos_reg <= short_pos_next;
            long_pos_reg  <= long_pos_next;
        end
    end

    // Payload bytes sit between header and tail.
    assign wr_en   = cmd.rx_take && (cur_pos != '0) && (cur_pos != cur_tail);
    assign wr_addr = cur_pos - POS_W'(1);

    // Read index: restarts at zero for a good frame, steps once per result.
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.rd_start)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.rd_next)
        begin
            rd_idx_next = rd_idx_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
        end
        else
        begin
            rd_idx_reg <= rd_idx_next;
        end
    end

    // Payload buffers, one per mode.
    htfs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SHORT_PAY),
        .AW    (SAW)
    ) u_short_ram (
        .clk   (clk),
        .we    (wr_en && !mode_reg),
        .waddr (wr_addr[SAW-1:0]),
        .wdata (rx_byte),
        .raddr (rd_idx_next[SAW-1:0]),
        .rdata (short_rdata)
    );

    htfs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LONG_PAY),
        .AW    (LAW)
    ) u_long_ram (
        .clk   (clk),
        .we    (wr_en && mode_reg),
        .waddr (wr_addr[LAW-1:0]),
        .wdata (rx_byte),
        .raddr (rd_idx_next[LAW-1:0]),
        .rdata (long_rdata)
    );

    assign rd_byte = mode_reg ? long_rdata : short_rdata;

    // Output register: index, byte times 43, and the end-of-frame mark.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            item_index_reg <= IDX_W'(rd_idx_reg);
            value_reg      <= VAL_W'({{(VAL_W-BYTE_W){1'b0}}, rd_byte} * SCALE_HUNDREDTHS);
            last_reg       <= status.rd_last;
        end
    end

    // Status toward the controller.
    assign status.tail_good = (cur_pos == cur_tail) && (rx_byte == TAIL_BYTE);
    assign status.rd_last   = (rd_idx_reg == (mode_reg ? LONG_LAST : SHORT_LAST));

    assign item_index       = item_index_reg;
    assign value_hundredths = value_reg;
    assign last             = last_reg;

endmodule

>>> src/htfs_ctrl.sv
// ----------------------------------------------------------------------------
// htfs_ctrl
// Controller: takes bytes, then unloads a good frame one result at a time.
// ----------------------------------------------------------------------------
module htfs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  htfs_pkg::status_t status,
    output htfs_pkg::cmd_t    cmd
);
    import htfs_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RX;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RX:
            begin
                if (in_valid && status.tail_good)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_ready)
                begin
                    state_next = status.rd_last ? ST_RX : ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_RX;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd.rx_take  = 1'b0;
        cmd.rd_start = 1'b0;
        cmd.rd_next  = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_RX:
            begin
                in_ready     = 1'b1;
                cmd.rx_take  = in_valid;
                cmd.rd_start = in_valid && status.tail_good;
            end
            ST_LOAD:
            begin
                cmd.out_load = 1'b1;
            end
            ST_HOLD:
            begin
                out_valid   = 1'b1;
                cmd.rd_next = out_ready && !status.rd_last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> src/header_tail_frame_scaler.sv
// ----------------------------------------------------------------------------
// header_tail_frame_scaler
// Fixed-length frame receiver that emits each payload byte scaled by 0.43.
// ----------------------------------------------------------------------------
// While receiving, the block takes one byte per clock. A frame starts with the
// header byte 0xE6 and ends with a tail byte; a good tail (0xFF) starts the
// unload, during which no byte is taken. Each result passes through a payload
// buffer read and the output register and is held until m_tready is high.
// The short and the long mode each keep their own position and buffer, and a
// mode change resumes the selected frame where it stopped.
module header_tail_frame_scaler #(
    parameter int SHORT_FRAME_BYTES = htfs_pkg::SHORT_FRAME_BYTES_DEF,
    parameter int LONG_FRAME_BYTES  = htfs_pkg::LONG_FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: frame_mode (0 short, 1 long).
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data,
    // Input stream. tdata: [7:0] rx_byte.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // Output stream. tdata: [5:0] item_index, [19:6] value_hundredths, [23:20] zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tlast
);
    import htfs_pkg::*;

    cmd_t             cmd;
    status_t          status;
    logic [IDX_W-1:0] item_index;
    logic [VAL_W-1:0] value_hundredths;

    // Configuration requests are always taken.
    assign cfg_ready = 1'b1;

    htfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    htfs_datapath #(
        .SHORT_FRAME_BYTES (SHORT_FRAME_BYTES),
        .LONG_FRAME_BYTES  (LONG_FRAME_BYTES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_mode         (cfg_data[0]),
        .rx_byte          (s_tdata),
        .cmd              (cmd),
        .status           (status),
        .item_index       (item_index),
        .value_hundredths (value_hundredths),
        .last             (m_tlast)
    );

    // Pack the result fields, lowest field first.
    assign m_tdata = {4'b0000, value_hundredths, item_index};

endmodule

>>> src/htfs_checker.sv
// ----------------------------------------------------------------------------
// htfs_checker
// Port-level checks of the frame scaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "header_tail_frame_scaler_assert.svh"

module htfs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    logic s_take;
    logic m_take;
    logic idx_zero;

    // Handshakes on both stream sides and the index field of the result.
    assign s_take   = s_tvalid && s_tready;
    assign m_take   = m_tvalid && m_tready;
    assign idx_zero = (m_tdata[5:0] == 6'd0);

    // No byte is taken while a result is offered.
    `HTFS_ASSERT(a_no_rx_during_unload, m_tvalid |-> !s_tready, "byte taken during unload")

    // Between two results of a frame m_tvalid drops while the output register is loaded.
    `HTFS_ASSERT(a_gap_between_results, (m_take && !m_tlast) |=> !m_tvalid, "missing read cycle")

    // After the final result the block listens for bytes again.
    `HTFS_ASSERT(a_rx_after_last, (m_take && m_tlast) |=> s_tready, "not receiving after last")

    // A frame's unload starts at payload index zero.
    `HTFS_ASSERT(a_first_index_zero, s_take ##2 m_tvalid |-> idx_zero, "unload index not zero")

endmodule

bind header_tail_frame_scaler htfs_checker u_checker (.*);
